// ----- hw/rtl/wsd_pkg.sv -----
`timescale 1ns / 1ps

package wsd_pkg;

  localparam int unsigned DefaultDepth      = 256;
  localparam int unsigned DefaultHandleBits = 32;
  localparam int unsigned OutQueueDepth     = 3;

  typedef enum logic [1:0] {
    REQ_PUSH  = 2'd0,
    REQ_POP   = 2'd1,
    REQ_STEAL = 2'd2
  } req_e;

  typedef enum logic [1:0] {
    STAT_DONE  = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_e;

  typedef struct packed {
    status_e status;
    logic    take;
  } res_ctrl_t;

endpackage

// ----- hw/rtl/wsd_ring.sv -----
`timescale 1ns / 1ps

module wsd_ring import wsd_pkg::*; #(
  parameter int unsigned DEPTH       = DefaultDepth,
  parameter int unsigned HANDLE_BITS = DefaultHandleBits,
  localparam int unsigned AW = $clog2(DEPTH),
  localparam int unsigned FW = $clog2(DEPTH + 1)
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   req_valid_i,
  input  logic [1:0]             req_type_i,
  input  logic [HANDLE_BITS-1:0] job_handle_i,
  output logic                   res_valid_o,
  output res_ctrl_t              res_ctrl_o,
  output logic [HANDLE_BITS-1:0] res_handle_o,
  output logic [FW-1:0]          res_fill_o
);

  localparam logic [AW-1:0] LastSlot = AW'(DEPTH - 1);
  localparam logic [FW-1:0] FullFill = FW'(DEPTH);

  logic [HANDLE_BITS-1:0] mem [DEPTH];
  logic [HANDLE_BITS-1:0] rd_q;

  logic [AW-1:0] top_q, top_d, bot_q, bot_d;
  logic [AW-1:0] top_inc, bot_inc, bot_dec, rd_addr;
  logic [FW-1:0] fill_q, fill_d, fill_out_q;
  logic          wr_en, rd_en;
  logic          valid_q;
  res_ctrl_t     ctrl_d, ctrl_q;

  assign top_inc = (top_q == LastSlot) ? '0 : top_q + AW'(1);
  assign bot_inc = (bot_q == LastSlot) ? '0 : bot_q + AW'(1);
  assign bot_dec = (bot_q == '0) ? LastSlot : bot_q - AW'(1);

  always_comb begin
    top_d   = top_q;
    bot_d   = bot_q;
    fill_d  = fill_q;
    wr_en   = 1'b0;
    rd_en   = 1'b0;
    rd_addr = top_q;
    ctrl_d  = '{status: STAT_DONE, take: 1'b0};
    if (req_valid_i) begin
      case (req_e'(req_type_i))
        REQ_PUSH: begin
          if (fill_q == FullFill) begin
            ctrl_d.status = STAT_FULL;
          end else begin
            wr_en  = 1'b1;
            bot_d  = bot_inc;
            fill_d = fill_q + FW'(1);
          end
        end
        REQ_POP: begin
          if (fill_q == '0) begin
            ctrl_d.status = STAT_EMPTY;
          end else begin
            rd_en       = 1'b1;
            rd_addr     = bot_dec;
            bot_d       = bot_dec;
            fill_d      = fill_q - FW'(1);
            ctrl_d.take = 1'b1;
          end
        end
        REQ_STEAL: begin
          if (fill_q == '0) begin
            ctrl_d.status = STAT_EMPTY;
          end else begin
            rd_en       = 1'b1;
            rd_addr     = top_q;
            top_d       = top_inc;
            fill_d      = fill_q - FW'(1);
            ctrl_d.take = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_q   <= '0;
      bot_q   <= '0;
      fill_q  <= '0;
      valid_q <= 1'b0;
    end else begin
      top_q   <= top_d;
      bot_q   <= bot_d;
      fill_q  <= fill_d;
      valid_q <= req_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[bot_q] <= job_handle_i;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_valid_i) begin
      ctrl_q     <= ctrl_d;
      fill_out_q <= fill_d;
    end
  end

  assign res_valid_o  = valid_q;
  assign res_ctrl_o   = ctrl_q;
  assign res_handle_o = ctrl_q.take ? rd_q : '0;
  assign res_fill_o   = fill_out_q;

endmodule

// ----- hw/rtl/wsd_outq.sv -----
`timescale 1ns / 1ps

module wsd_outq import wsd_pkg::*; #(
  parameter int unsigned DEPTH = OutQueueDepth,
  parameter int unsigned WIDTH = 8,
  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned CW = $clog2(DEPTH + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] data_o,
  output logic [CW-1:0]    count_o
);

  localparam logic [PW-1:0] LastPtr = PW'(DEPTH - 1);

  logic [WIDTH-1:0] entry_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    count_q, count_d;
  logic             do_pop;

  assign do_pop = pop_i && (count_q != '0);

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PW'(1);
    end
    if (push_i && !do_pop) begin
      count_d = count_q + CW'(1);
    end else if (!push_i && do_pop) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= data_i;
    end
  end

  assign valid_o = (count_q != '0);
  assign data_o  = entry_q[rd_ptr_q];
  assign count_o = count_q;

endmodule

// ----- hw/rtl/work_stealing_deque.sv -----
`timescale 1ns / 1ps
// A result is registered in the ring and then in the result queue.
// Throughput: one request per cycle if the three-entry result queue has room,
// set by the single ring store port and the registered read of that store.
// Reset: top, bottom and fill are cleared at once; the ring store keeps no
// reset value and needs no clearing pass, so requests are taken right away.

module work_stealing_deque import wsd_pkg::*; #(
  parameter int unsigned DEPTH       = DefaultDepth,
  parameter int unsigned HANDLE_BITS = DefaultHandleBits,
  localparam int unsigned FW = $clog2(DEPTH + 1)
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [1:0]             req_type_i,
  input  logic [HANDLE_BITS-1:0] job_handle_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [1:0]             status_o,
  output logic [HANDLE_BITS-1:0] taken_handle_o,
  output logic [FW-1:0]          fill_count_o
);

  localparam int unsigned QW = 2 + HANDLE_BITS + FW;
  localparam int unsigned CW = $clog2(OutQueueDepth + 1);

  logic                   in_fire;
  logic                   res_valid;
  res_ctrl_t              res_ctrl;
  logic [HANDLE_BITS-1:0] res_handle;
  logic [FW-1:0]          res_fill;
  logic [QW-1:0]          q_in, q_out;
  logic [CW-1:0]          q_count;
  logic [CW:0]            in_flight;

  assign in_flight  = {1'b0, q_count} + {{CW{1'b0}}, res_valid};
  assign in_ready_o = (in_flight < (CW + 1)'(OutQueueDepth));
  assign in_fire    = in_valid_i && in_ready_o;

  wsd_ring #(
    .DEPTH      (DEPTH),
    .HANDLE_BITS(HANDLE_BITS)
  ) u_ring (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (in_fire),
    .req_type_i  (req_type_i),
    .job_handle_i(job_handle_i),
    .res_valid_o (res_valid),
    .res_ctrl_o  (res_ctrl),
    .res_handle_o(res_handle),
    .res_fill_o  (res_fill)
  );

  assign q_in = {res_ctrl.status, res_handle, res_fill};

  wsd_outq #(
    .DEPTH(OutQueueDepth),
    .WIDTH(QW)
  ) u_outq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_valid),
    .data_i (q_in),
    .pop_i  (out_ready_i),
    .valid_o(out_valid_o),
    .data_o (q_out),
    .count_o(q_count)
  );

  assign status_o       = q_out[QW-1 -: 2];
  assign taken_handle_o = q_out[FW +: HANDLE_BITS];
  assign fill_count_o   = q_out[FW-1:0];

  a_fire_reaches_ring: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> res_valid)
    else $error("Accepted request did not reach the result stage.");

  a_queue_never_overruns: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_flight <= (CW + 1)'(OutQueueDepth))
    else $error("More results in flight than the result queue can hold.");

  a_refused_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o == STAT_FULL)) |-> (fill_count_o == FW'(DEPTH)))
    else $error("Push refused while the deque was not full.");

  a_empty_takes_nothing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o == STAT_EMPTY)) |->
      ((fill_count_o == '0) && (taken_handle_o == '0)))
    else $error("Empty report with a nonzero fill or handle.");

endmodule
